@@ hw/rtl/tsrrs_pkg.sv @@
// ---------------------------------------------------------------------------
// tsrrs_pkg
// shared constants for the round robin thread slot scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package tsrrs_pkg;

    // slot table geometry
    localparam int THREAD_SLOTS = 16;
    localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);
    localparam int ID_W         = 4;

    // slot states
    typedef logic [1:0] slot_st_t;
    localparam slot_st_t ST_UNUSED   = 2'd0;
    localparam slot_st_t ST_ALIVE    = 2'd1;
    localparam slot_st_t ST_FINISHED = 2'd2;

    // actions
    typedef logic [1:0] action_t;
    localparam action_t ACT_CREATE = 2'd0;
    localparam action_t ACT_YIELD  = 2'd1;
    localparam action_t ACT_FINISH = 2'd2;
    localparam action_t ACT_JOIN   = 2'd3;

    // status codes
    typedef logic [1:0] status_t;
    localparam status_t RC_OK      = 2'd0;
    localparam status_t RC_FULL    = 2'd1;
    localparam status_t RC_INVALID = 2'd2;
    localparam status_t RC_BUSY    = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/thread_slot_round_robin_scheduler_unit.sv @@
// ---------------------------------------------------------------------------
// thread_slot_round_robin_scheduler_unit
// thread slot table with create, yield, finish and join events
// ---------------------------------------------------------------------------
// paths: a join of an out-of-range id goes straight to the result; a join of an unused
//   or finished slot reads its status first; yield and finish scan the other slots,
//   and create and a busy join scan as well (one status read per scan cycle)
// flow: one word in flight; the next word is taken the cycle after its
//   result enters the output register, which waits for m_ready when it is full
// reset: synchronous active-low, then a clearing pass over every slot
//   writes the status memory (slot 0 alive) before s_ready rises
`default_nettype none

module thread_slot_round_robin_scheduler_unit
    import tsrrs_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    // input channel
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  [1:0]              s_action,
    input  wire  [7:0]              s_target_id,
    input  wire  signed [31:0]      s_result_value,
    // result channel
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_status_code,
    output logic [ID_W-1:0]         m_created_id,
    output logic signed [31:0]      m_exit_value,
    output logic [ID_W-1:0]         m_running_id
);

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;  // clearing pass after reset
    localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a word
    localparam logic [2:0] S_SCAN = 3'd2;  // walking the status memory
    localparam logic [2:0] S_JOIN = 3'd3;  // join target status is back
    localparam logic [2:0] S_DONE = 3'd4;  // result ready for output register

    // slot storage: status and exit value memories, registered read
    slot_st_t          stat_mem [THREAD_SLOTS];
    logic [31:0]       ex_mem   [THREAD_SLOTS];

    slot_st_t          stat_rd_reg;
    logic [31:0]       ex_rd_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic              stat_we;
    logic [SLOT_W-1:0] stat_wa;
    slot_st_t          stat_wd;
    logic              ex_we;
    logic [SLOT_W-1:0] ex_wa;
    logic [31:0]       ex_wd;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;     // next address to read in a scan
    logic [SLOT_W-1:0] pidx_reg, pidx_next;   // address read last cycle
    logic              pend_reg, pend_next;   // a scan read is in flight
    logic [CNT_W-1:0]  cnt_reg, cnt_next;     // scan reads issued so far
    logic              mk_reg, mk_next;       // scan looks for a free slot
    logic [SLOT_W-1:0] tgt_reg, tgt_next;

    // result being built
    status_t           code_reg, code_next;
    logic [SLOT_W-1:0] crt_reg, crt_next;
    logic [31:0]       exv_reg, exv_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    status_t           m_code_reg, m_code_next;
    logic [ID_W-1:0]   m_crt_reg, m_crt_next;
    logic [31:0]       m_exv_reg, m_exv_next;
    logic [ID_W-1:0]   m_run_reg, m_run_next;

    logic [CNT_W-1:0]  scan_total;
    logic              scan_hit;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(THREAD_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // memories
    always_ff @(posedge aclk) begin
        if (stat_we) begin
            stat_mem[stat_wa] <= stat_wd;
        end
        if (ex_we) begin
            ex_mem[ex_wa] <= ex_wd;
        end
        stat_rd_reg <= stat_mem[rd_addr];
        ex_rd_reg   <= ex_mem[rd_addr];
    end

    // create scans every slot from zero; yield, finish and a busy join scan the others after current
    assign scan_total = mk_reg ? CNT_W'(THREAD_SLOTS) : CNT_W'(THREAD_SLOTS - 1);
    assign scan_hit   = pend_reg &&
                        (stat_rd_reg == (mk_reg ? ST_UNUSED : ST_ALIVE));

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        ptr_next     = ptr_reg;
        pidx_next    = pidx_reg;
        pend_next    = 1'b0;
        cnt_next     = cnt_reg;
        mk_next      = mk_reg;
        tgt_next     = tgt_reg;
        code_next    = code_reg;
        crt_next     = crt_reg;
        exv_next     = exv_reg;
        rd_addr      = '0;
        stat_we      = 1'b0;
        stat_wa      = '0;
        stat_wd      = ST_UNUSED;
        ex_we        = 1'b0;
        ex_wa        = cur_reg;
        ex_wd        = s_result_value;

        // output register drains independently of the sequencer
        m_valid_next = m_valid_reg && !m_ready;
        m_code_next  = m_code_reg;
        m_crt_next   = m_crt_reg;
        m_exv_next   = m_exv_reg;
        m_run_next   = m_run_reg;

        case (state_reg)
            S_CLR: begin
                stat_we  = 1'b1;
                stat_wa  = clr_reg;
                stat_wd  = (clr_reg == '0) ? ST_ALIVE : ST_UNUSED;
                clr_next = slot_inc(clr_reg);
                if (clr_reg == SLOT_W'(THREAD_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    code_next = RC_OK;
                    crt_next  = '0;
                    exv_next  = '0;
                    cnt_next  = '0;
                    tgt_next  = s_target_id[SLOT_W-1:0];
                    case (s_action)
                        ACT_CREATE: begin
                            mk_next    = 1'b1;
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                        ACT_YIELD: begin
                            mk_next    = 1'b0;
                            ptr_next   = slot_inc(cur_reg);
                            state_next = S_SCAN;
                        end
                        ACT_FINISH: begin
                            // store exit value, mark finished, then yield
                            ex_we      = 1'b1;
                            stat_we    = 1'b1;
                            stat_wa    = cur_reg;
                            stat_wd    = ST_FINISHED;
                            mk_next    = 1'b0;
                            ptr_next   = slot_inc(cur_reg);
                            state_next = S_SCAN;
                        end
                        default: begin
                            if (s_target_id < 8'(THREAD_SLOTS)) begin
                                rd_addr    = s_target_id[SLOT_W-1:0];
                                state_next = S_JOIN;
                            end else begin
                                code_next  = RC_INVALID;
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (scan_hit) begin
                    if (mk_reg) begin
                        stat_we  = 1'b1;
                        stat_wa  = pidx_reg;
                        stat_wd  = ST_ALIVE;
                        crt_next = pidx_reg;
                    end else begin
                        cur_next = pidx_reg;
                    end
                    state_next = S_DONE;
                end else if (!pend_reg && cnt_reg == scan_total) begin
                    // nothing found: create is full, yield stays put
                    if (mk_reg) begin
                        code_next = RC_FULL;
                    end
                    state_next = S_DONE;
                end else if (cnt_reg != scan_total) begin
                    rd_addr   = ptr_reg;
                    pidx_next = ptr_reg;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    ptr_next  = slot_inc(ptr_reg);
                end
            end

            S_JOIN: begin
                if (stat_rd_reg == ST_UNUSED) begin
                    code_next  = RC_INVALID;
                    state_next = S_DONE;
                end else if (stat_rd_reg == ST_FINISHED) begin
                    stat_we    = 1'b1;
                    stat_wa    = tgt_reg;
                    stat_wd    = ST_UNUSED;
                    exv_next   = ex_rd_reg;
                    state_next = S_DONE;
                end else begin
                    // still alive: report busy and yield
                    code_next  = RC_BUSY;
                    mk_next    = 1'b0;
                    cnt_next   = '0;
                    ptr_next   = slot_inc(cur_reg);
                    state_next = S_SCAN;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_code_next  = code_reg;
                    m_crt_next   = ID_W'(crt_reg);
                    m_exv_next   = exv_reg;
                    m_run_next   = ID_W'(cur_reg);
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            cur_reg     <= '0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            mk_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            mk_reg      <= mk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        pidx_reg   <= pidx_next;
        tgt_reg    <= tgt_next;
        code_reg   <= code_next;
        crt_reg    <= crt_next;
        exv_reg    <= exv_next;
        m_code_reg <= m_code_next;
        m_crt_reg  <= m_crt_next;
        m_exv_reg  <= m_exv_next;
        m_run_reg  <= m_run_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status_code = m_code_reg;
    assign m_created_id  = m_crt_reg;
    assign m_exit_value  = m_exv_reg;
    assign m_running_id  = m_run_reg;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the round robin thread slot scheduler
//
// A driver process feeds event words (create, yield, finish, join) from a
// queue that the stimulus block fills. Each accepted word runs through a
// behavioral copy of the slot table. The predicted result goes into a
// queue, and the monitor checks every output word against it, field by
// field. Both sides idle in random bursts. The receiver holds off once for a
// long stretch, and the sender waits twice for the table to drain.
// ---------------------------------------------------------------------------

module tb_top;
    import tsrrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RANDOM_WORDS = 1900;
    localparam int CALM_TAIL    = 150;    // last words run with no idling
    localparam int HOLD_AT      = 600;    // result count that starts the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 1000;   // random word that waits for an empty pipeline
    localparam int TAIL_CYCLES  = 40;     // above the worst search latency of the block

    // one input word as the sender sees it
    typedef struct {
        action_t            act;
        logic [7:0]         target;
        logic signed [31:0] value;
        bit                 drain_first;  // hold until every result has come back
    } sched_word_t;

    // one result word
    typedef struct {
        status_t            status;
        logic [ID_W-1:0]    created;
        logic signed [31:0] exit_val;
        logic [ID_W-1:0]    running;
    } sched_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // dut ports, inputs known from time zero
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action       = '0;
    logic [7:0]         s_target_id    = '0;
    logic signed [31:0] s_result_value = '0;
    logic               m_valid;
    logic               m_ready        = 1'b1;
    logic [1:0]         m_status_code;
    logic [ID_W-1:0]    m_created_id;
    logic signed [31:0] m_exit_value;
    logic [ID_W-1:0]    m_running_id;

    thread_slot_round_robin_scheduler_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_target_id    (s_target_id),
        .s_result_value (s_result_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status_code  (m_status_code),
        .m_created_id   (m_created_id),
        .m_exit_value   (m_exit_value),
        .m_running_id   (m_running_id)
    );

    // ------------------------------------------------------------------
    // shadow slot table, advanced once per accepted word
    // ------------------------------------------------------------------
    slot_st_t           slot_state [THREAD_SLOTS];
    logic signed [31:0] slot_exit  [THREAD_SLOTS];
    int                 sched_cur;

    // move to the next alive slot after the current one, wrapping around;
    // stay put when no other slot is alive
    function automatic void rotate_to_next_alive();
        int cand;
        for (int k = 1; k < THREAD_SLOTS; k++) begin
            cand = (sched_cur + k) % THREAD_SLOTS;
            if (slot_state[cand] == ST_ALIVE) begin
                sched_cur = cand;
                return;
            end
        end
    endfunction

    function automatic sched_result_t schedule_event(sched_word_t w);
        sched_result_t r;
        r.status   = RC_OK;
        r.created  = '0;
        r.exit_val = '0;
        case (w.act)
            ACT_CREATE: begin
                // lowest unused slot wins, current thread unchanged
                r.status = RC_FULL;
                for (int i = 0; i < THREAD_SLOTS; i++) begin
                    if (r.status == RC_FULL && slot_state[i] == ST_UNUSED) begin
                        slot_state[i] = ST_ALIVE;
                        r.created     = ID_W'(i);
                        r.status      = RC_OK;
                    end
                end
            end
            ACT_YIELD: begin
                rotate_to_next_alive();
            end
            ACT_FINISH: begin
                // stored and marked even when the current slot is not alive
                slot_exit[sched_cur]  = w.value;
                slot_state[sched_cur] = ST_FINISHED;
                rotate_to_next_alive();
            end
            ACT_JOIN: begin
                if (w.target >= THREAD_SLOTS || slot_state[w.target] == ST_UNUSED) begin
                    r.status = RC_INVALID;
                end else if (slot_state[w.target] == ST_FINISHED) begin
                    // collect and free, no yield
                    slot_state[w.target] = ST_UNUSED;
                    r.exit_val           = slot_exit[w.target];
                end else begin
                    // still alive: one poll, then give the core away
                    r.status = RC_BUSY;
                    rotate_to_next_alive();
                end
            end
        endcase
        r.running = ID_W'(sched_cur);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    sched_word_t   pending_words [$];
    sched_result_t due_results   [$];
    int            total_words;
    int            accept_cnt   = 0;
    int            result_cnt   = 0;
    int            mismatch_cnt = 0;
    int            action_seen [4];
    int            status_seen [4];

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("t=%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: one word at a time from pending_words, with idle bursts
    // ------------------------------------------------------------------
    int          gap_left    = 0;
    int          send_window = 0;
    bit          send_busy   = 1'b0;
    sched_word_t cur_word;

    always @(posedge aclk) begin : driver
        logic next_valid;
        bit   calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            calm       = (accept_cnt + CALM_TAIL >= total_words);

            // word taken at this edge: predict it now, in acceptance order
            if (s_valid && s_ready) begin
                due_results.push_back(schedule_event(cur_word));
                action_seen[cur_word.act]++;
                accept_cnt++;
                next_valid = 1'b0;
            end

            // alternate between windows with idle bursts and windows without
            if (send_window == 0) begin
                send_window = $urandom_range(20, 120);
                send_busy   = ($urandom_range(0, 2) != 0);
            end else begin
                send_window--;
            end

            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    if (pending_words[0].drain_first && due_results.size() != 0) begin
                        // sender pause: wait for the table to go quiet
                    end else if (!calm && send_busy && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(0, 15);
                    end else begin
                        cur_word       = pending_words.pop_front();
                        next_valid     = 1'b1;
                        s_action       <= cur_word.act;
                        s_target_id    <= cur_word.target;
                        s_result_value <= cur_word.value;
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result words and drives m_ready
    // ------------------------------------------------------------------
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int recv_window = 0;
    bit recv_busy   = 1'b0;

    always @(posedge aclk) begin : monitor
        sched_result_t want;
        logic          next_ready;
        bit            calm;
        if (!aresetn) begin
            m_ready <= 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    mismatch_cnt++;
                    $display("t=%0t: result word with none expected, expected nothing, actual %0h",
                             $time, m_status_code);
                end else begin
                    want = due_results.pop_front();
                    compare_field("status_code", want.status,   m_status_code);
                    compare_field("created_id",  want.created,  m_created_id);
                    compare_field("exit_value",  want.exit_val, m_exit_value);
                    compare_field("running_id",  want.running,  m_running_id);
                end
                status_seen[m_status_code]++;
                result_cnt++;
            end

            calm = (result_cnt + CALM_TAIL >= total_words);

            // one long hold-off so the block backs up into its input side
            if (!hold_done && result_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (recv_window == 0) begin
                recv_window = $urandom_range(20, 120);
                recv_busy   = ($urandom_range(0, 2) != 0);
            end else begin
                recv_window--;
            end

            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (calm) begin
                next_ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (recv_busy && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 15);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_ready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    function automatic void add_word(action_t act, logic [7:0] target,
                                     logic signed [31:0] value, bit drain_first);
        sched_word_t w;
        w.act         = act;
        w.target      = target;
        w.value       = value;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endfunction

    initial begin : stimulus
        int      bias;
        int      pick;
        action_t act;
        logic [7:0] target;

        // reset state of the shadow table: slot 0 alive and current
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_state[i] = ST_UNUSED;
            slot_exit[i]  = '0;
        end
        slot_state[0] = ST_ALIVE;
        sched_cur     = 0;
        for (int i = 0; i < 4; i++) begin
            action_seen[i] = 0;
            status_seen[i] = 0;
        end

        // directed opening
        add_word(ACT_JOIN,   8'd255,              32'sd0, 1'b0);  // far out of range
        add_word(ACT_JOIN,   8'(THREAD_SLOTS),    32'sd0, 1'b0);  // first id past the table
        add_word(ACT_JOIN,   8'd1,                32'sd0, 1'b0);  // unused slot
        add_word(ACT_YIELD,  8'd0,                32'sd0, 1'b0);  // nobody else alive
        add_word(ACT_JOIN,   8'd0,                32'sd0, 1'b0);  // join of self while alive
        add_word(ACT_FINISH, 8'd0, 32'sh8000_0000, 1'b0);         // last alive thread exits
        add_word(ACT_FINISH, 8'hff, 32'sh7fff_ffff, 1'b0);        // finish of a finished slot
        add_word(ACT_JOIN,   8'd0,                32'sd0, 1'b0);  // collect the current slot
        for (int i = 0; i < THREAD_SLOTS; i++)
            add_word(ACT_CREATE, 8'd0, 32'sd0, 1'b0);             // fill every slot
        add_word(ACT_CREATE, 8'd0,                32'sd0, 1'b0);  // table full

        // random part in segments, each with its own mix of events
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0)
                bias = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            case (bias)
                0:       act = (pick < 50) ? ACT_CREATE : (pick < 65) ? ACT_YIELD :
                               (pick < 85) ? ACT_FINISH : ACT_JOIN;
                1:       act = action_t'(pick % 4);
                default: act = (pick < 15) ? ACT_CREATE : (pick < 30) ? ACT_YIELD :
                               (pick < 60) ? ACT_FINISH : ACT_JOIN;
            endcase
            if (act == ACT_JOIN && $urandom_range(0, 99) < 85)
                target = 8'($urandom_range(0, THREAD_SLOTS - 1));
            else
                target = 8'($urandom_range(0, 255));
            add_word(act, target, $urandom, (n == 0) || (n == DRAIN_AT));
        end
        total_words = pending_words.size();

        // reset held once, then released
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // all words taken and answered, then a quiet tail for stray words
        while (accept_cnt < total_words || due_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("ran %0d words: %0d create, %0d yield, %0d finish, %0d join",
                 accept_cnt, action_seen[ACT_CREATE], action_seen[ACT_YIELD],
                 action_seen[ACT_FINISH], action_seen[ACT_JOIN]);
        $display("statuses seen: %0d ok, %0d full, %0d invalid, %0d busy; %0d mismatches",
                 status_seen[RC_OK], status_seen[RC_FULL], status_seen[RC_INVALID],
                 status_seen[RC_BUSY], mismatch_cnt);
        if (mismatch_cnt == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("t=%0t: run did not finish, %0d of %0d words answered",
                 $time, result_cnt, total_words);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ thread_slot_round_robin_scheduler_unit.f @@
hw/rtl/tsrrs_pkg.sv
hw/rtl/thread_slot_round_robin_scheduler_unit.sv
sim/tb_top.sv
